// ===== src/nitnn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nitnn_pkg
// Shared constants for the NIT network name extractor.
// ----------------------------------------------------------------------------
package nitnn_pkg;

    // default sizes
    localparam int DEF_MAX_NAME    = 30;
    localparam int DEF_MAX_SECTION = 1024;

    // stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;   // byte(8) + index(5) + length(5), padded
    localparam int OUT_TUSER_W = 1;
    localparam int IDX_W       = 5;    // name_index / name_length field width

    // section layout
    localparam int LOOP_W        = 12;
    localparam int NDP_W         = 14;
    localparam int LEN_POS_HI    = 8;
    localparam int LEN_POS_LO    = 9;
    localparam int DESC_START    = 10;
    localparam int DESC_OVERHEAD = 2;
    localparam int MIN_SECTION   = 24;

    localparam logic [7:0] NAME_TAG     = 8'h40;
    localparam logic [7:0] LOOP_HI_MASK = 8'h0F;

endpackage

// ===== src/nitnn_name_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nitnn_name_ram
// Name byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nitnn_name_ram #(
    parameter int DEPTH = 30,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/nitnn_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nitnn_parser
// Section byte walker: loop length, descriptor seek, name copy into the store.
// ----------------------------------------------------------------------------
module nitnn_parser #(
    parameter int MAX_NAME    = nitnn_pkg::DEF_MAX_NAME,
    parameter int MAX_SECTION = nitnn_pkg::DEF_MAX_SECTION,
    parameter int NAME_W      = $clog2(MAX_NAME + 1),
    parameter int AW          = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic              i_end,
    input  logic              i_emit_busy,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output logic [7:0]        o_wdata,
    output logic              o_start,
    output logic [NAME_W-1:0] o_count
);
    import nitnn_pkg::*;

    localparam int POS_W = $clog2(MAX_SECTION + 1);

    typedef enum logic [2:0] {
        PH_HEADER, PH_SEEK, PH_SKIPLEN, PH_NAMELEN, PH_COPY, PH_DONE
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [LOOP_W-1:0]   r_loop, n_loop;
    logic [NDP_W-1:0]    r_ndp, n_ndp;
    logic [NAME_W-1:0]   r_kept, n_kept;
    logic [NAME_W-1:0]   r_copied, n_copied;
    logic                accept;
    logic                take;

    assign o_ready = !i_emit_busy;
    assign accept  = i_valid && o_ready;
    assign take    = accept && (r_pos < POS_W'(MAX_SECTION));
    assign o_waddr = AW'(r_copied);
    assign o_wdata = i_byte;

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_loop   = r_loop;
        n_ndp    = r_ndp;
        n_kept   = r_kept;
        n_copied = r_copied;
        o_we     = 1'b0;
        o_start  = 1'b0;
        o_count  = '0;

        if (take) begin
            n_pos = r_pos + 1'b1;
            if (r_pos == POS_W'(LEN_POS_HI)) begin
                n_loop = LOOP_W'(i_byte & LOOP_HI_MASK) << 8;
            end else if (r_pos == POS_W'(LEN_POS_LO)) begin
                n_loop = r_loop | LOOP_W'(i_byte);
            end
            case (r_phase)
                PH_HEADER: begin
                    if (r_pos == POS_W'(LEN_POS_LO)) n_phase = PH_SEEK;
                end
                PH_SEEK: begin
                    if (NDP_W'(r_pos) == r_ndp) begin
                        if ((r_ndp - NDP_W'(DESC_START)) >= NDP_W'(r_loop)) begin
                            n_phase = PH_DONE;
                        end else if (i_byte == NAME_TAG) begin
                            n_phase = PH_NAMELEN;
                        end else begin
                            n_phase = PH_SKIPLEN;
                        end
                    end
                end
                PH_SKIPLEN: begin
                    n_ndp   = r_ndp + NDP_W'(i_byte) + NDP_W'(DESC_OVERHEAD);
                    n_phase = PH_SEEK;
                end
                PH_NAMELEN: begin
                    n_kept   = (i_byte > 8'(MAX_NAME)) ? NAME_W'(MAX_NAME)
                                                       : NAME_W'(i_byte);
                    n_copied = '0;
                    n_phase  = (i_byte == 8'd0) ? PH_DONE : PH_COPY;
                end
                PH_COPY: begin
                    if (r_copied < r_kept) begin
                        o_we     = 1'b1;
                        n_copied = r_copied + 1'b1;
                    end
                    if (n_copied >= r_kept) n_phase = PH_DONE;
                end
                default: ;
            endcase
        end

        // end of section: hand the count over, then back to reset values
        if (accept && i_end) begin
            o_start  = 1'b1;
            o_count  = (n_pos <= POS_W'(MIN_SECTION)) ? '0 : n_copied;
            n_phase  = PH_HEADER;
            n_pos    = '0;
            n_loop   = '0;
            n_ndp    = NDP_W'(DESC_START);
            n_kept   = '0;
            n_copied = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_loop   <= '0;
            r_ndp    <= NDP_W'(DESC_START);
            r_kept   <= '0;
            r_copied <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_loop   <= n_loop;
            r_ndp    <= n_ndp;
            r_kept   <= n_kept;
            r_copied <= n_copied;
        end
    end

    a_copy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_copied <= r_kept)
        else $error("copied count exceeds kept length");

    a_copy_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_COPY |-> r_copied < r_kept)
        else $error("copy phase with nothing left to copy");

endmodule

// ===== src/nitnn_emitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nitnn_emitter
// Reads the kept name back from the store and drives the result beats.
// ----------------------------------------------------------------------------
module nitnn_emitter #(
    parameter int MAX_NAME = nitnn_pkg::DEF_MAX_NAME,
    parameter int NAME_W   = $clog2(MAX_NAME + 1),
    parameter int AW       = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [NAME_W-1:0]                   i_count,
    output logic                                o_busy,
    output logic                                o_re,
    output logic [AW-1:0]                       o_raddr,
    input  logic [7:0]                          i_rdata,
    output logic                                o_tvalid,
    input  logic                                i_tready,
    output logic [nitnn_pkg::OUT_TDATA_W-1:0]   o_tdata,
    output logic [nitnn_pkg::OUT_TUSER_W-1:0]   o_tuser,
    output logic                                o_tlast
);
    import nitnn_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_LOAD, S_SHOW} t_state;

    t_state              r_state;
    logic [NAME_W-1:0]   r_count;
    logic [NAME_W-1:0]   r_idx;
    logic [NAME_W-1:0]   idx_nxt;
    logic [7:0]          r_byte;
    logic [IDX_W-1:0]    r_index;
    logic [IDX_W-1:0]    r_length;
    logic                r_found;
    logic                r_last;
    logic                r_valid;
    logic                beat;

    assign idx_nxt = r_idx + 1'b1;
    assign beat    = (r_state == S_SHOW) && i_tready;
    assign o_busy  = (r_state != S_IDLE);

    // next read issues on the accepted beat so the byte sits in the store's read register by the load state
    assign o_re    = (r_state == S_READ) || (beat && !r_last);
    assign o_raddr = (r_state == S_SHOW) ? AW'(idx_nxt) : AW'(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_count <= i_count;
                        r_idx   <= '0;
                        if (i_count == '0) begin
                            r_byte   <= '0;
                            r_index  <= '0;
                            r_length <= '0;
                            r_found  <= 1'b0;
                            r_last   <= 1'b1;
                            r_valid  <= 1'b1;
                            r_state  <= S_SHOW;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_byte   <= i_rdata;
                    r_index  <= IDX_W'(r_idx);
                    r_length <= IDX_W'(r_count);
                    r_found  <= 1'b1;
                    r_last   <= (idx_nxt == r_count);
                    r_valid  <= 1'b1;
                    r_state  <= S_SHOW;
                end
                S_SHOW: begin
                    if (i_tready) begin
                        r_valid <= 1'b0;
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= idx_nxt;
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = OUT_TDATA_W'({r_length, r_index, r_byte});
    assign o_tuser  = OUT_TUSER_W'(r_found);
    assign o_tlast  = r_last;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == S_IDLE)
        else $error("section handed over while a name is still going out");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOAD |=> r_valid && r_state == S_SHOW)
        else $error("loaded byte not presented");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_last && r_found |-> IDX_W'(r_index + 1'b1) == r_length)
        else $error("last beat does not close the name");

endmodule

// ===== src/dvb_nit_network_name_extractor.sv =====
`timescale 1ns / 1ps
// Throughput: one section byte per cycle while no name is being sent out.
// First result beat: after the end-of-section beat the emitter reads the name store, then
//   loads the byte into the output register; each further name byte again waits for a read
//   through the single read port of the store and a load. A no-name result needs no store read.
// The input stalls from the end-of-section beat until the final result beat is taken.
// Reset: synchronous, active low; the name store is not cleared (no clearing pass).
// ----------------------------------------------------------------------------
// dvb_nit_network_name_extractor
// Pulls the network name descriptor out of one NIT section and sends the name
// bytes out after the section ends.
// ----------------------------------------------------------------------------
module dvb_nit_network_name_extractor #(
    parameter int MAX_NAME    = nitnn_pkg::DEF_MAX_NAME,
    parameter int MAX_SECTION = nitnn_pkg::DEF_MAX_SECTION
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input beats: one section byte each
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [nitnn_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [7:0] section_byte
    input  logic                               s_axis_tlast,  // end_of_section
    // result beats: one name byte each, or a single no-name beat
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [nitnn_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [7:0] name_byte,
                                                              // [12:8] name_index,
                                                              // [17:13] name_length,
                                                              // [23:18] zero
    output logic [nitnn_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,  // [0] found
    output logic                               m_axis_tlast   // last
);
    import nitnn_pkg::*;

    localparam int NAME_W = $clog2(MAX_NAME + 1);
    localparam int AW     = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;

    // store write side (parser) and read side (emitter)
    logic              we;
    logic [AW-1:0]     waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [AW-1:0]     raddr;
    logic [7:0]        rdata;

    // section hand-over; a zero count means the no-name result
    logic              start;
    logic [NAME_W-1:0] count;
    logic              emit_busy;

    // The parser is held off while the emitter reads the store, so a read
    // never meets a write of the next section.
    nitnn_parser #(
        .MAX_NAME    (MAX_NAME),
        .MAX_SECTION (MAX_SECTION),
        .NAME_W      (NAME_W),
        .AW          (AW)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_end       (s_axis_tlast),
        .i_emit_busy (emit_busy),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_start     (start),
        .o_count     (count)
    );

    nitnn_name_ram #(
        .DEPTH   (MAX_NAME),
        .AW      (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    nitnn_emitter #(
        .MAX_NAME (MAX_NAME),
        .NAME_W   (NAME_W),
        .AW       (AW)
    ) u_emitter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_count  (count),
        .o_busy   (emit_busy),
        .o_re     (re),
        .o_raddr  (raddr),
        .i_rdata  (rdata),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule
